[rtl/mlre_pkg.sv]
package mlre_pkg;

   localparam int unsigned NumRegs = 6;

   typedef enum logic [1:0] {
      ITEM_TICK    = 2'd0,
      ITEM_RX_BYTE = 2'd1,
      ITEM_CURRENT = 2'd2,
      ITEM_SPEED   = 2'd3
   } item_type;

   typedef enum logic [2:0] {
      RK_SET_CURRENT = 3'd0,
      RK_SET_SPEED   = 3'd1,
      RK_STATUS      = 3'd2,
      RK_CURRENT     = 3'd3,
      RK_VOLTAGE     = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      OC_OK       = 3'd0,
      OC_TOO_FEW  = 3'd1,
      OC_TOO_MANY = 3'd2,
      OC_OPCODE   = 3'd3,
      OC_CHECKSUM = 3'd4
   } outcome_type;

   typedef enum logic [2:0] {
      REG_AMP_STEPS   = 3'd0,
      REG_VOLT_STEPS  = 3'd1,
      REG_GAP         = 3'd2,
      REG_TIMEOUT     = 3'd3,
      REG_STATUS_PER  = 3'd4,
      REG_SPEED_STEPS = 3'd5
   } reg_index_type;

   localparam logic [7:0] FrameStart = 8'hAA;

   // One unit of work queued from the front part to the back part.
   typedef struct packed {
      logic       judge;     // 1: judge a reply, 0: send a request
      logic [2:0] req;
      logic       has_data;
      logic [7:0] data;      // request data byte (speed data is raw percent)
   } cmd_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [2:0]  request_kind;
      logic [2:0]  outcome;
      logic [15:0] reply_value;
      logic [15:0] motor_status;
      logic [15:0] current_x10;
      logic [15:0] voltage_x10;
   } rsp_type;

   function automatic logic [7:0] opcode_of(input logic [2:0] k);
      logic [7:0] op;
      begin
         unique case (k)
            RK_SET_CURRENT: op = 8'h64;
            RK_SET_SPEED:   op = 8'h63;
            RK_CURRENT:     op = 8'h41;
            RK_VOLTAGE:     op = 8'h42;
            default:        op = 8'h40;
         endcase
         return op;
      end
   endfunction

endpackage

[rtl/mlre_if.sv]
interface mlre_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] value;
   modport source (output valid, req_type, value, input ready);
   modport sink (input valid, req_type, value, output ready);
endinterface

interface mlre_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  tx_byte;
   logic        last;
   logic [2:0]  request_kind;
   logic [2:0]  outcome;
   logic [15:0] reply_value;
   logic [15:0] motor_status;
   logic [15:0] current_x10;
   logic [15:0] voltage_x10;
   modport source (output valid, kind, tx_byte, last, request_kind, outcome, reply_value,
                   motor_status, current_x10, voltage_x10, input ready);
   modport sink (input valid, kind, tx_byte, last, request_kind, outcome, reply_value,
                 motor_status, current_x10, voltage_x10, output ready);
endinterface

interface mlre_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/mlre_div.sv]
// Restoring divider, one quotient bit a cycle.
module mlre_div
   import mlre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [25:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic [15:0] quotient
);
   logic [25:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [16:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff[15:0], quot_ff[25]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = 5'd26;
         busy_in = 1'b1;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // shift in one bit, subtract when it fits
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in  = trial - {1'b0, dsr_ff};
            quot_in = {quot_ff[24:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[24:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = (dsr_ff == 16'd0) ? 16'hFFFF : quot_ff[15:0];
endmodule

[rtl/mlre_front.sv]
// Accept items, track timers and targets, buffer received bytes, queue commands.
module mlre_front
   import mlre_pkg::*;
#(
   parameter int unsigned RX_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   mlre_req_if.sink   req,
   input  logic [7:0] gap_ms,
   input  logic [7:0] timeout_ms,
   input  logic [9:0] status_per_ms,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       back_done,
   input  logic [$clog2(RX_DEPTH)-1:0] rd_addr,
   output logic [7:0] rd_data,
   output logic [$clog2(RX_DEPTH+1)-1:0] rx_count
);
   localparam int unsigned AW = $clog2(RX_DEPTH);
   localparam int unsigned CW = $clog2(RX_DEPTH + 1);

   logic [7:0]    store_mem [RX_DEPTH];
   logic [7:0]    rd_data_ff;
   logic          waiting_ff, waiting_in;
   logic [2:0]    pend_ff, pend_in;
   logic [15:0]   since_req_ff, since_req_in, since_st_ff, since_st_in;
   logic [1:0]    rsel_ff, rsel_in;
   logic [6:0]    cur_t_ff, cur_t_in, spd_t_ff, spd_t_in;
   logic          cur_p_ff, cur_p_in, spd_p_ff, spd_p_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] jcnt_ff;
   logic          busy_ff, busy_in;
   logic          cmd_v_ff, cmd_v_in;
   cmd_type       cmd_ff, cmd_in;
   logic          acc;
   logic [6:0]    pct;
   logic [15:0]   sr, ss;
   logic [2:0]    len;

   // one command in flight: accept again when the back part is done
   assign req.ready = !busy_ff;
   assign acc       = req.valid && !busy_ff;
   assign pct       = (req.value > 8'd100) ? 7'd100 : req.value[6:0];
   assign sr        = (since_req_ff == 16'hFFFF) ? since_req_ff : since_req_ff + 16'd1;
   assign ss        = (since_st_ff == 16'hFFFF) ? since_st_ff : since_st_ff + 16'd1;
   assign len       = (pend_ff == RK_STATUS || pend_ff == RK_VOLTAGE) ? 3'd5 : 3'd4;

   always_comb begin
      waiting_in   = waiting_ff;
      pend_in      = pend_ff;
      since_req_in = since_req_ff;
      since_st_in  = since_st_ff;
      rsel_in      = rsel_ff;
      cur_t_in     = cur_t_ff;
      spd_t_in     = spd_t_ff;
      cur_p_in     = cur_p_ff;
      spd_p_in     = spd_p_ff;
      cnt_in       = cnt_ff;
      busy_in      = busy_ff;
      cmd_v_in     = 1'b0;
      cmd_in       = cmd_ff;
      if (back_done) busy_in = 1'b0;
      if (acc) begin
         unique case (item_type'(req.req_type))
            ITEM_TICK: begin
               since_req_in = sr;
               since_st_in  = ss;
               if (waiting_ff) begin
                  if ({1'b0, cnt_ff} >= (CW+1)'(len) || sr > {8'd0, timeout_ms}) begin
                     cmd_v_in = 1'b1;
                     busy_in  = 1'b1;
                     cmd_in   = '{judge: 1'b1, req: pend_ff, has_data: 1'b0, data: 8'd0};
                     cnt_in   = '0;
                     waiting_in = 1'b0;
                     if (pend_ff == RK_STATUS) rsel_in = 2'd1;
                     else if (pend_ff == RK_CURRENT) rsel_in = 2'd2;
                     else if (pend_ff == RK_VOLTAGE) rsel_in = 2'd0;
                  end
               end else if (sr >= {8'd0, gap_ms}) begin
                  priority if (cur_p_ff) begin
                     cur_p_in = 1'b0;
                     cmd_in   = '{judge: 1'b0, req: RK_SET_CURRENT, has_data: 1'b1,
                                  data: {1'b0, cur_t_ff}};
                     cmd_v_in = 1'b1;
                  end else if (spd_p_ff) begin
                     spd_p_in = 1'b0;
                     cmd_in   = '{judge: 1'b0, req: RK_SET_SPEED, has_data: 1'b1,
                                  data: {1'b0, spd_t_ff}};
                     cmd_v_in = 1'b1;
                  end else if (ss > {6'd0, status_per_ms}) begin
                     cmd_in   = '{judge: 1'b0, req: 3'(3'd2 + {1'b0, rsel_ff}),
                                  has_data: 1'b0, data: 8'd0};
                     cmd_v_in = 1'b1;
                     if (rsel_ff == 2'd0) since_st_in = '0;
                  end
                  if (cmd_v_in) begin
                     busy_in      = 1'b1;
                     pend_in      = cmd_in.req;
                     since_req_in = '0;
                     waiting_in   = 1'b1;
                  end
               end
            end
            ITEM_RX_BYTE: begin
               if (cnt_ff < CW'(RX_DEPTH)) cnt_in = cnt_ff + CW'(1);
            end
            ITEM_CURRENT: begin
               if (pct != cur_t_ff) begin
                  cur_t_in = pct;
                  cur_p_in = 1'b1;
               end
            end
            ITEM_SPEED: begin
               if (pct != spd_t_ff) begin
                  spd_t_in = pct;
                  spd_p_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff   <= 1'b0;
         pend_ff      <= RK_SET_CURRENT;
         since_req_ff <= 16'hFFFF;
         since_st_ff  <= 16'hFFFF;
         rsel_ff      <= 2'd0;
         cur_t_ff     <= '0;
         spd_t_ff     <= '0;
         cur_p_ff     <= 1'b1;
         spd_p_ff     <= 1'b1;
         cnt_ff       <= '0;
         busy_ff      <= 1'b0;
         cmd_v_ff     <= 1'b0;
      end else begin
         waiting_ff   <= waiting_in;
         pend_ff      <= pend_in;
         since_req_ff <= since_req_in;
         since_st_ff  <= since_st_in;
         rsel_ff      <= rsel_in;
         cur_t_ff     <= cur_t_in;
         spd_t_ff     <= spd_t_in;
         cur_p_ff     <= cur_p_in;
         spd_p_ff     <= spd_p_in;
         cnt_ff       <= cnt_in;
         busy_ff      <= busy_in;
         cmd_v_ff     <= cmd_v_in;
      end
      cmd_ff <= cmd_in;
      // hold the byte count seen by the command for the back part
      if (cmd_v_in) jcnt_ff <= cnt_ff;
   end

   // write received bytes, registered read for the back part
   always_ff @(posedge clock) begin
      if (acc && req.req_type == ITEM_RX_BYTE && cnt_ff < CW'(RX_DEPTH))
         store_mem[cnt_ff[AW-1:0]] <= req.value;
      rd_data_ff <= store_mem[rd_addr];
   end

   assign cmd_valid = cmd_v_ff;
   assign cmd       = cmd_ff;
   assign rd_data   = rd_data_ff;
   assign rx_count  = jcnt_ff;
endmodule

[rtl/mlre_back.sv]
// Carry out one command: emit request bytes or judge the buffered reply.
module mlre_back
   import mlre_pkg::*;
#(
   parameter int unsigned RX_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        back_done,
   output logic [$clog2(RX_DEPTH)-1:0] rd_addr,
   input  logic [7:0]  rd_data,
   input  logic [$clog2(RX_DEPTH+1)-1:0] rx_count,
   input  logic [9:0]  amp_steps,
   input  logic [15:0] volt_steps,
   input  logic [7:0]  speed_full,
   mlre_rsp_if.source  rsp
);
   localparam int unsigned AW = $clog2(RX_DEPTH);
   localparam int unsigned CW = $clog2(RX_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SPD_MUL, S_SPD_SUM, S_TX, S_RD1, S_RD2, S_RD3, S_RD4,
      S_JUDGE, S_SCALE, S_DIV, S_REPORT
   } state_type;

   state_type   state_ff;
   cmd_type     cmd_ff;
   logic [1:0]  txi_ff;
   logic [7:0]  data_ff, sum_ff;
   logic [7:0]  b1_ff, b2_ff, b3_ff;
   logic [CW-1:0] cnt_ff;
   logic [2:0]  oc_ff;
   logic [15:0] reply_ff;
   logic [15:0] st_ff, amp_ff, volt_ff;
   logic        done_ff;
   logic [15:0] prod_ff;
   rsp_type     out_ff;
   logic        out_v_ff;
   logic        out_load;
   logic        div_start, div_busy;
   logic [25:0] div_num;
   logic [15:0] div_den, div_q;
   logic        five;
   logic [7:0]  op;
   logic [7:0]  chk;
   logic [7:0]  tx_cur;
   logic        tx_last;
   logic [15:0] rv;
   logic [26:0] spd_prod;
   logic [7:0]  spd_q;

   assign five = (cmd_ff.req == RK_STATUS || cmd_ff.req == RK_VOLTAGE);
   assign op   = opcode_of(cmd_ff.req);
   assign chk  = five ? 8'(b1_ff + b2_ff + b3_ff) : 8'(b1_ff + b2_ff);
   assign rv   = five ? {b2_ff, b3_ff} : {8'd0, b2_ff};

   // speed byte: divide by one hundred through a reciprocal multiply
   assign spd_prod = 27'(prod_ff) * 27'd5243;
   assign spd_q    = spd_prod[26:19];

   // current byte of the outgoing frame
   always_comb begin
      unique case (txi_ff)
         2'd0:    tx_cur = FrameStart;
         2'd1:    tx_cur = op;
         2'd2:    tx_cur = cmd_ff.has_data ? data_ff : sum_ff;
         default: tx_cur = sum_ff;
      endcase
      tx_last = (txi_ff == 2'd3) || (txi_ff == 2'd2 && !cmd_ff.has_data);
   end

   // in the transmit and report states, load the output register whenever it frees up
   assign out_load = (state_ff == S_TX || state_ff == S_REPORT) && (!out_v_ff || rsp.ready);

   assign div_start = (state_ff == S_SCALE) && (oc_ff == OC_OK) &&
                      (cmd_ff.req == RK_CURRENT || cmd_ff.req == RK_VOLTAGE);
   always_comb begin
      if (cmd_ff.req == RK_CURRENT) begin
         div_num = 26'(reply_ff) * 26'd100;
         div_den = {6'd0, amp_steps};
      end else begin
         div_num = 26'(reply_ff) * 26'd1000;
         div_den = volt_steps;
      end
   end

   mlre_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         done_ff  <= 1'b0;
         st_ff    <= '0;
         amp_ff   <= '0;
         volt_ff  <= '0;
         txi_ff   <= '0;
      end else begin
         done_ff <= out_load && (state_ff == S_REPORT || tx_last);
         if (out_load) out_v_ff <= 1'b1;
         else if (rsp.ready) out_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff  <= cmd;
                  data_ff <= cmd.data;
                  txi_ff  <= '0;
                  cnt_ff  <= rx_count;
                  if (cmd.judge) state_ff <= S_RD1;
                  else if (cmd.req == RK_SET_SPEED) state_ff <= S_SPD_MUL;
                  else state_ff <= S_TX;
                  if (!cmd.judge && cmd.req == RK_SET_SPEED)
                     prod_ff <= {8'd0, speed_full} * {9'd0, cmd.data[6:0]};
                  sum_ff <= 8'(opcode_of(cmd.req) + (cmd.has_data ? cmd.data : 8'd0));
               end
            end
            S_SPD_MUL: begin
               data_ff  <= spd_q;
               state_ff <= S_SPD_SUM;
            end
            S_SPD_SUM: begin
               sum_ff   <= 8'(op + data_ff);
               state_ff <= S_TX;
            end
            S_TX: begin
               // emit one frame byte per free output slot
               if (out_load) begin
                  out_ff   <= '{kind: 1'b0, tx_byte: tx_cur, last: tx_last,
                                request_kind: cmd_ff.req, outcome: OC_OK,
                                reply_value: 16'd0, motor_status: st_ff,
                                current_x10: amp_ff, voltage_x10: volt_ff};
                  txi_ff <= txi_ff + 2'd1;
                  if (tx_last) state_ff <= S_IDLE;
               end
            end
            S_RD1: state_ff <= S_RD2;
            S_RD2: begin b1_ff <= rd_data; state_ff <= S_RD3; end
            S_RD3: begin b2_ff <= rd_data; state_ff <= S_RD4; end
            S_RD4: begin
               b3_ff <= rd_data;
               state_ff <= S_JUDGE;
            end
            S_JUDGE: begin
               // byte four arrives now; decide outcome
               state_ff <= S_SCALE;
               if (cnt_ff < CW'(five ? 5 : 4)) oc_ff <= OC_TOO_FEW;
               else if (cnt_ff > CW'(five ? 5 : 4)) oc_ff <= OC_TOO_MANY;
               else if (b1_ff != op) oc_ff <= OC_OPCODE;
               else if (chk != (five ? rd_data : b3_ff)) oc_ff <= OC_CHECKSUM;
               else oc_ff <= OC_OK;
               reply_ff <= rv;
            end
            S_SCALE: begin
               // start scaling of a good reading, or update status directly
               if (div_start) begin
                  state_ff <= S_DIV;
               end else begin
                  if (oc_ff == OC_OK && cmd_ff.req == RK_STATUS) st_ff <= reply_ff;
                  state_ff <= S_REPORT;
               end
            end
            S_DIV: begin
               if (!div_busy) begin
                  if (cmd_ff.req == RK_CURRENT) amp_ff <= div_q;
                  else volt_ff <= div_q;
                  state_ff <= S_REPORT;
               end
            end
            S_REPORT: begin
               if (out_load) begin
                  out_ff   <= '{kind: 1'b1, tx_byte: 8'd0, last: 1'b1,
                                request_kind: cmd_ff.req, outcome: oc_ff,
                                reply_value: (oc_ff == OC_OK) ? reply_ff : 16'd0,
                                motor_status: st_ff, current_x10: amp_ff,
                                voltage_x10: volt_ff};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // read address for the reply bytes at positions one to four
   always_comb begin
      unique case (state_ff)
         S_RD1:   rd_addr = AW'(1);
         S_RD2:   rd_addr = AW'(2);
         S_RD3:   rd_addr = AW'(3);
         default: rd_addr = AW'(4);
      endcase
   end

   assign back_done        = done_ff;
   assign rsp.valid        = out_v_ff;
   assign rsp.kind         = out_ff.kind;
   assign rsp.tx_byte      = out_ff.tx_byte;
   assign rsp.last         = out_ff.last;
   assign rsp.request_kind = out_ff.request_kind;
   assign rsp.outcome      = out_ff.outcome;
   assign rsp.reply_value  = out_ff.reply_value;
   assign rsp.motor_status = out_ff.motor_status;
   assign rsp.current_x10  = out_ff.current_x10;
   assign rsp.voltage_x10  = out_ff.voltage_x10;
endmodule

[rtl/motor_link_request_engine_core.sv]
// Items without a result leave the input ready. A request tick's command, registered
//   in the front part, is taken by the back part, which loads its first byte into the
//   output register; a speed set passes S_SPD_MUL and S_SPD_SUM first. A judging
//   tick judges the buffered reply and reports; a current or voltage read first waits
//   on the 26-step divider that scales the reading. One tick is worked at a time:
//   input stalls until its last result's registered done flag clears the busy state.
//   Reset: synchronous, active high; restores register defaults and link state.
module motor_link_request_engine_core
   import mlre_pkg::*;
#(
   parameter int unsigned RX_DEPTH = 8
) (
   input  logic      clock,
   input  logic      reset,
   mlre_req_if.sink  req,
   mlre_rsp_if.source rsp,
   mlre_csr_if.sink  csr
);
   localparam int unsigned AW = $clog2(RX_DEPTH);
   localparam int unsigned CW = $clog2(RX_DEPTH + 1);

   logic [9:0]  amp_ff;
   logic [15:0] volt_ff;
   logic [7:0]  gap_ff, tmo_ff, spd_ff;
   logic [9:0]  per_ff;
   logic        cmd_valid, back_done;
   cmd_type     cmd;
   logic [AW-1:0] rd_addr;
   logic [7:0]  rd_data;
   logic [CW-1:0] rx_count;

   // configuration registers
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff  <= 10'd69;
         volt_ff <= 16'd1490;
         gap_ff  <= 8'd32;
         tmo_ff  <= 8'd32;
         per_ff  <= 10'd200;
         spd_ff  <= 8'd250;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_AMP_STEPS:   amp_ff  <= csr.data[9:0];
            REG_VOLT_STEPS:  volt_ff <= csr.data;
            REG_GAP:         gap_ff  <= csr.data[7:0];
            REG_TIMEOUT:     tmo_ff  <= csr.data[7:0];
            REG_STATUS_PER:  per_ff  <= csr.data[9:0];
            REG_SPEED_STEPS: spd_ff  <= csr.data[7:0];
            default: ;
         endcase
      end
   end

   mlre_front #(.RX_DEPTH(RX_DEPTH)) u_front (
      .clock, .reset, .req,
      .gap_ms(gap_ff), .timeout_ms(tmo_ff), .status_per_ms(per_ff),
      .cmd_valid, .cmd, .back_done, .rd_addr, .rd_data, .rx_count
   );

   mlre_back #(.RX_DEPTH(RX_DEPTH)) u_back (
      .clock, .reset, .cmd_valid, .cmd, .back_done, .rd_addr, .rd_data,
      .rx_count, .amp_steps(amp_ff), .volt_steps(volt_ff),
      .speed_full(spd_ff), .rsp
   );
endmodule

[rtl/mlre_checker.sv]
module mlre_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic       rsp_last,
   input logic [2:0] rsp_outcome,
   input logic [7:0] rsp_tx_byte
);
   // hold valid and the tx byte while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte))
      else $error("rsp payload changed under stall");
   // a report is always the last of its item
   a_rep_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_last)
      else $error("report without last");
   // transmit bytes carry ok outcome
   a_tx_oc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_outcome == 3'd0)
      else $error("transmit byte with outcome");
endmodule

bind motor_link_request_engine_core mlre_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_kind(rsp.kind), .rsp_last(rsp.last), .rsp_outcome(rsp.outcome),
   .rsp_tx_byte(rsp.tx_byte)
);

[tb/motor_link_request_engine_core_tb.sv]
`timescale 1ns / 1ps

module motor_link_request_engine_core_tb;
   import mlre_pkg::*;

   localparam int unsigned RxDepth = 8;
   localparam int unsigned CycleLimit = 1000000;
   localparam int unsigned SettleCycles = 80;

   // Link master predictor and store of expected link bytes and reports
   class link_scoreboard;
      logic [9:0]  amp_steps;
      logic [15:0] volt_steps;
      logic [7:0]  gap_ms;
      logic [7:0]  timeout_ms;
      logic [9:0]  period_ms;
      logic [7:0]  speed_full;

      bit          waiting;
      logic [2:0]  pending_req;
      logic [15:0] since_req;
      logic [15:0] since_stat;
      logic [1:0]  read_sel;
      logic [6:0]  cur_target;
      bit          cur_dirty;
      logic [6:0]  spd_target;
      bit          spd_dirty;
      logic [7:0]  rx_buf [RxDepth];
      int unsigned rx_count;
      logic [15:0] status_word;
      logic [15:0] amps_x10;
      logic [15:0] volts_x10;

      rsp_type     expected_q[$];
      int unsigned errors;

      function void init();
         amp_steps   = 10'd69;
         volt_steps  = 16'd1490;
         gap_ms      = 8'd32;
         timeout_ms  = 8'd32;
         period_ms   = 10'd200;
         speed_full  = 8'd250;
         waiting     = 0;
         pending_req = RK_SET_CURRENT;
         since_req   = 16'hFFFF;
         since_stat  = 16'hFFFF;
         read_sel    = 2'd0;
         cur_target  = '0;
         cur_dirty   = 1;
         spd_target  = '0;
         spd_dirty   = 1;
         rx_count    = 0;
         status_word = '0;
         amps_x10    = '0;
         volts_x10   = '0;
         errors      = 0;
         foreach (rx_buf[i]) rx_buf[i] = '0;
      endfunction

      function void write_reg(reg_index_type idx, logic [15:0] val);
         case (idx)
            REG_AMP_STEPS:   amp_steps  = val[9:0];
            REG_VOLT_STEPS:  volt_steps = val;
            REG_GAP:         gap_ms     = val[7:0];
            REG_TIMEOUT:     timeout_ms = val[7:0];
            REG_STATUS_PER:  period_ms  = val[9:0];
            REG_SPEED_STEPS: speed_full = val[7:0];
            default: ;
         endcase
      endfunction

      function int unsigned reply_len(logic [2:0] k);
         return (k == RK_STATUS || k == RK_VOLTAGE) ? 5 : 4;
      endfunction

      function void emit(logic kind, logic [7:0] b, logic [2:0] k, logic [2:0] oc,
                         logic [15:0] reply);
         rsp_type r;
         r.kind = kind;
         r.tx_byte = b;
         r.last = 1'b0;
         r.request_kind = k;
         r.outcome = oc;
         r.reply_value = reply;
         r.motor_status = status_word;
         r.current_x10 = amps_x10;
         r.voltage_x10 = volts_x10;
         expected_q.push_back(r);
      endfunction

      function void send_frame(logic [2:0] k, bit has_data, logic [7:0] data);
         logic [7:0] op;
         op = opcode_of(k);
         emit(1'b0, FrameStart, k, OC_OK, '0);
         emit(1'b0, op, k, OC_OK, '0);
         if (has_data) begin
            emit(1'b0, data, k, OC_OK, '0);
            op = op + data;
         end
         emit(1'b0, op, k, OC_OK, '0);
         pending_req = k;
         since_req = '0;
         waiting = 1;
      endfunction

      function void judge_reply();
         int unsigned len;
         logic [2:0]  oc;
         logic [15:0] data;
         logic [7:0]  sum;
         len = reply_len(pending_req);
         data = '0;
         sum = '0;
         if (rx_count < len) oc = OC_TOO_FEW;
         else if (rx_count > len) oc = OC_TOO_MANY;
         else if (rx_buf[1] != opcode_of(pending_req)) oc = OC_OPCODE;
         else begin
            for (int j = 1; j + 1 < len; j++) sum = sum + rx_buf[j];
            if (sum != rx_buf[len-1]) oc = OC_CHECKSUM;
            else begin
               oc = OC_OK;
               data = (len == 5) ? {rx_buf[2], rx_buf[3]} : {8'd0, rx_buf[2]};
            end
         end
         // Update readings only on a clean reply
         if (oc == OC_OK) begin
            if (pending_req == RK_STATUS) status_word = data;
            else if (pending_req == RK_CURRENT)
               amps_x10 = (amp_steps == 0) ? 16'hFFFF
                          : 16'((32'(data) * 100) / amp_steps);
            else if (pending_req == RK_VOLTAGE)
               volts_x10 = (volt_steps == 0) ? 16'hFFFF
                           : 16'((32'(data) * 1000) / volt_steps);
         end
         // Advance the read rotation whatever the outcome
         if (pending_req == RK_STATUS) read_sel = 2'd1;
         else if (pending_req == RK_CURRENT) read_sel = 2'd2;
         else if (pending_req == RK_VOLTAGE) read_sel = 2'd0;
         rx_count = 0;
         waiting = 0;
         emit(1'b1, 8'd0, pending_req, oc, data);
      endfunction

      function void tick();
         logic [2:0] k;
         if (since_req != 16'hFFFF) since_req++;
         if (since_stat != 16'hFFFF) since_stat++;
         if (waiting) begin
            if (rx_count >= reply_len(pending_req) || since_req > timeout_ms) judge_reply();
         end else if (since_req >= gap_ms) begin
            if (cur_dirty) begin
               cur_dirty = 0;
               send_frame(RK_SET_CURRENT, 1, {1'b0, cur_target});
            end else if (spd_dirty) begin
               spd_dirty = 0;
               send_frame(RK_SET_SPEED, 1, 8'((16'(speed_full) * spd_target) / 100));
            end else if (since_stat > period_ms) begin
               k = 3'(RK_STATUS + (read_sel > 2 ? 0 : read_sel));
               if (k == RK_STATUS) since_stat = '0;
               send_frame(k, 0, '0);
            end
         end
      endfunction

      // Note one accepted input transaction
      function void note_item(item_type t, logic [7:0] v);
         int unsigned before_n;
         logic [6:0]  pct;
         before_n = expected_q.size();
         pct = (v > 100) ? 7'd100 : v[6:0];
         case (t)
            ITEM_TICK: tick();
            ITEM_RX_BYTE: begin
               if (rx_count < RxDepth) begin
                  rx_buf[rx_count] = v;
                  rx_count++;
               end
            end
            ITEM_CURRENT: if (pct != cur_target) begin
               cur_target = pct;
               cur_dirty = 1;
            end
            default: if (pct != spd_target) begin
               spd_target = pct;
               spd_dirty = 1;
            end
         endcase
         if (expected_q.size() > before_n) expected_q[$].last = 1'b1;
      endfunction

      function void field_cmp(string name, logic [15:0] exp_v, logic [15:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         end
      endfunction

      // Check one accepted result transaction against the oldest expectation
      function void check_result(rsp_type got);
         rsp_type w;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            return;
         end
         w = expected_q.pop_front();
         field_cmp("kind", w.kind, got.kind);
         field_cmp("tx_byte", w.tx_byte, got.tx_byte);
         field_cmp("last", w.last, got.last);
         field_cmp("request_kind", w.request_kind, got.request_kind);
         field_cmp("outcome", w.outcome, got.outcome);
         field_cmp("reply_value", w.reply_value, got.reply_value);
         field_cmp("motor_status", w.motor_status, got.motor_status);
         field_cmp("current_x10", w.current_x10, got.current_x10);
         field_cmp("voltage_x10", w.voltage_x10, got.voltage_x10);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   mlre_req_if req_ch ();
   mlre_rsp_if rsp_ch ();
   mlre_csr_if csr_ch ();

   motor_link_request_engine_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   link_scoreboard link_sb;
   bit             calm = 0;
   bit             hold_request = 0;
   int unsigned    hold_left = 0;
   int unsigned    cycle_count = 0;

   always #10 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.req_type = ITEM_TICK;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_AMP_STEPS;
      csr_ch.data = '0;
   end

   // Abort on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Drive result ready with random stalls and a single long hold-off; check results
   always @(posedge clock) begin
      rsp_type got;
      if (rsp_ch.valid && rsp_ch.ready && !reset) begin
         got.kind = rsp_ch.kind;
         got.tx_byte = rsp_ch.tx_byte;
         got.last = rsp_ch.last;
         got.request_kind = rsp_ch.request_kind;
         got.outcome = rsp_ch.outcome;
         got.reply_value = rsp_ch.reply_value;
         got.motor_status = rsp_ch.motor_status;
         got.current_x10 = rsp_ch.current_x10;
         got.voltage_x10 = rsp_ch.voltage_x10;
         link_sb.check_result(got);
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_request && hold_left == 0) begin
         hold_left = 400;
         hold_request = 0;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= 12);
      end
   end

   task automatic write_csr(reg_index_type idx, logic [15:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      link_sb.write_reg(idx, val);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [15:0] amp, logic [15:0] volt, logic [15:0] gap,
                            logic [15:0] tmo, logic [15:0] per, logic [15:0] spd);
      write_csr(REG_AMP_STEPS, amp);
      write_csr(REG_VOLT_STEPS, volt);
      write_csr(REG_GAP, gap);
      write_csr(REG_TIMEOUT, tmo);
      write_csr(REG_STATUS_PER, per);
      write_csr(REG_SPEED_STEPS, spd);
   endtask

   task automatic send_item(item_type t, logic [7:0] v);
      if (!calm) begin
         while ($urandom_range(99) < 12) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= t;
      req_ch.value <= v;
      do @(posedge clock); while (!req_ch.ready);
      link_sb.note_item(t, v);
   endtask

   // Hold until every expected result is in, then let the block settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (link_sb.expected_q.size() > 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Send a reply to the awaited request, mostly well formed
   task automatic send_reply();
      logic [7:0]  frame [$];
      logic [7:0]  sum;
      int unsigned len;
      int unsigned mode;
      len = link_sb.reply_len(link_sb.pending_req);
      mode = $urandom_range(9);
      frame.push_back($urandom_range(3) == 0 ? FrameStart : 8'($urandom));
      frame.push_back(mode == 7 ? 8'($urandom) : opcode_of(link_sb.pending_req));
      for (int i = 2; i < len - 1; i++) frame.push_back(8'($urandom));
      sum = '0;
      for (int i = 1; i < len - 1; i++) sum = sum + frame[i];
      frame.push_back(mode == 8 ? sum ^ 8'(1 << $urandom_range(7)) : sum);
      if (mode == 9) begin
         if ($urandom_range(1)) void'(frame.pop_back());
         else frame.push_back(8'($urandom));
      end
      foreach (frame[i]) send_item(ITEM_RX_BYTE, frame[i]);
   endtask

   task automatic random_phase(int unsigned n_items);
      int unsigned sent;
      int unsigned r;
      logic [7:0]  v;
      sent = 0;
      while (sent < n_items) begin
         if (link_sb.waiting && link_sb.rx_count == 0 && $urandom_range(9) < 8) begin
            send_reply();
            sent += 4;
         end else begin
            r = $urandom_range(99);
            v = ($urandom_range(4) == 0) ? 8'($urandom_range(1) ? 255 : 100) : 8'($urandom);
            if (r < 60) send_item(ITEM_TICK, 8'($urandom));
            else if (r < 70) send_item(ITEM_RX_BYTE, 8'($urandom));
            else if (r < 85) send_item(ITEM_CURRENT, v);
            else send_item(ITEM_SPEED, v);
            sent++;
         end
      end
      drain();
   endtask

   initial begin
      link_sb = new();
      link_sb.init();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: clamp, unchecked frame start, checksum error, full buffer, timeout
      configure(16'd1, 16'd1, 16'd1, 16'd3, 16'd1, 16'd255);
      send_item(ITEM_CURRENT, 8'd200);
      send_item(ITEM_SPEED, 8'd255);
      send_item(ITEM_TICK, 8'd0);
      send_item(ITEM_RX_BYTE, 8'h00);
      send_item(ITEM_RX_BYTE, 8'h64);
      send_item(ITEM_RX_BYTE, 8'h05);
      send_item(ITEM_RX_BYTE, 8'h69);
      send_item(ITEM_TICK, 8'hFF);
      send_item(ITEM_TICK, 8'd0);
      send_item(ITEM_RX_BYTE, FrameStart);
      send_item(ITEM_RX_BYTE, 8'h63);
      send_item(ITEM_RX_BYTE, 8'hFF);
      send_item(ITEM_RX_BYTE, 8'h63);
      send_item(ITEM_TICK, 8'd0);
      send_item(ITEM_TICK, 8'd0);
      for (int i = 0; i < 9; i++) send_item(ITEM_RX_BYTE, 8'(i * 31));
      send_item(ITEM_TICK, 8'd0);
      repeat (5) send_item(ITEM_TICK, 8'd0);
      drain();

      // Random phases across register settings
      configure(16'd69, 16'd1490, 16'd2, 16'd6, 16'd10, 16'd250);
      random_phase(80);
      configure(16'd1023, 16'd65535, 16'd1, 16'd1, 16'd1, 16'd1);
      random_phase(70);
      configure(16'd7, 16'd1, 16'd255, 16'd255, 16'd1023, 16'd128);
      random_phase(30);
      configure(16'd0, 16'd0, 16'd4, 16'd8, 16'd2, 16'd100);
      hold_request = 1;
      random_phase(70);
      configure(16'd1, 16'd1, 16'd1, 16'd4, 16'd1, 16'd77);
      random_phase(60);
      calm = 1;
      configure(16'd500, 16'd3000, 16'd1, 16'd4, 16'd5, 16'd200);
      random_phase(90);

      if (link_sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[motor_link_request_engine_core.f]
rtl/mlre_pkg.sv
rtl/mlre_if.sv
rtl/mlre_div.sv
rtl/mlre_front.sv
rtl/mlre_back.sv
rtl/motor_link_request_engine_core.sv
rtl/mlre_checker.sv
tb/motor_link_request_engine_core_tb.sv
